// ----- rtl/core/evtq_pkg.sv -----
// Shared types, constants and defaults for the timed event sorted queue.
package evtq_pkg;

	localparam int unsigned DEF_QUEUE_DEPTH = 16;
	localparam int unsigned DEF_TIME_BITS   = 32;

	localparam int unsigned IN_TIME_W = 32;
	localparam int unsigned PIN_W     = 8;
	localparam int unsigned ACT_W     = 2;
	localparam int unsigned KIND_W    = 2;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_FIRED    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_CMP,
		ST_ADD_WR,
		ST_RESP,
		ST_CHK_CMP,
		ST_CHK_FLUSH
	} state_t;

endpackage

// ----- rtl/core/evtq_cmd_if.sv -----
// Command channel: add an event or check for due events.
interface evtq_cmd_if;
	import evtq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [IN_TIME_W-1:0] event_time;
	logic [PIN_W-1:0]     pin_number;
	logic [ACT_W-1:0]     pin_action;
	logic [IN_TIME_W-1:0] current_time;

	modport source (
		output valid, command, event_time, pin_number, pin_action, current_time,
		input  ready
	);

	modport sink (
		input  valid, command, event_time, pin_number, pin_action, current_time,
		output ready
	);
endinterface

// ----- rtl/core/evtq_res_if.sv -----
// Result channel: add answers and fired events.
interface evtq_res_if;
	import evtq_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [PIN_W-1:0]  fired_pin;
	logic [ACT_W-1:0]  fired_action;
	logic              last_result;

	modport source (
		output valid, result_kind, fired_pin, fired_action, last_result,
		input  ready
	);

	modport sink (
		input  valid, result_kind, fired_pin, fired_action, last_result,
		output ready
	);
endinterface

// ----- rtl/core/evtq_mem.sv -----
// Event store: one write port, one read port with registered read data.
module evtq_mem #(
	parameter int unsigned DEPTH = evtq_pkg::DEF_QUEUE_DEPTH,
	parameter int unsigned WIDTH = evtq_pkg::DEF_TIME_BITS + evtq_pkg::PIN_W + evtq_pkg::ACT_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so the controller may stall on it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ----- rtl/core/timed_event_sorted_queue.sv -----
// Top level: sorted event ring controller around the event store.
// Add: a full queue rejects the event, an empty one writes it directly; otherwise each entry
//   later than the new one moves one slot towards the tail, one read-compare-write per cycle.
// Check: with nothing stored no result is given; otherwise the head is read and compared once
//   per cycle unless a fired event is stalled. The next command is taken on return to idle.
// Reset clears state, head, count and both valid flags; the store needs no clearing.
module timed_event_sorted_queue #(
	parameter int unsigned QUEUE_DEPTH = evtq_pkg::DEF_QUEUE_DEPTH,
	parameter int unsigned TIME_BITS   = evtq_pkg::DEF_TIME_BITS
) (
	input logic             clk,
	input logic             arst_n,
	evtq_cmd_if.sink        cmd,
	evtq_res_if.source      res
);
	import evtq_pkg::*;

	localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned ENTRY_W = TIME_BITS + PIN_W + ACT_W;

	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
	                                             input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		begin
			s = {1'b0, head} + {1'b0, off};
			if (s >= (IDX_W+1)'(QUEUE_DEPTH)) begin
				s = s - (IDX_W+1)'(QUEUE_DEPTH);
			end
			return s[IDX_W-1:0];
		end
	endfunction

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     pos_q;
	logic [TIME_BITS-1:0] key_q;
	logic [PIN_W-1:0]     pin_q;
	logic [ACT_W-1:0]     act_q;
	kind_t                resp_kind_q;
	logic                 pend_valid_q;
	logic [PIN_W-1:0]     pend_pin_q;
	logic [ACT_W-1:0]     pend_act_q;

	logic                 out_valid_q;
	kind_t                out_kind_q;
	logic [PIN_W-1:0]     out_pin_q;
	logic [ACT_W-1:0]     out_act_q;
	logic                 out_last_q;

	logic                 rd_en, wr_en;
	logic [IDX_W-1:0]     rd_addr, wr_addr;
	logic [ENTRY_W-1:0]   wr_data, rd_data;
	logic [TIME_BITS-1:0] rd_time;
	logic [PIN_W-1:0]     rd_pin;
	logic [ACT_W-1:0]     rd_act;

	logic                 emit;
	kind_t                emit_kind;
	logic [PIN_W-1:0]     emit_pin;
	logic [ACT_W-1:0]     emit_act;
	logic                 emit_last;

	logic                 acc, out_free, le, stall, q_full, q_empty;
	logic [TIME_BITS-1:0] evt_t, now_t;
	logic [CNT_W-1:0]     cnt_m1;
	logic [ENTRY_W-1:0]   new_entry;

	assign evt_t     = TIME_BITS'(cmd.event_time);
	assign now_t     = TIME_BITS'(cmd.current_time);
	assign acc       = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign q_full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty   = (count_q == '0);
	assign cnt_m1    = count_q - CNT_W'(1);
	assign new_entry = {key_q, pin_q, act_q};

	assign rd_time = rd_data[ENTRY_W-1 -: TIME_BITS];
	assign rd_pin  = rd_data[ACT_W +: PIN_W];
	assign rd_act  = rd_data[ACT_W-1:0];

	// One comparator serves both commands: stop shifting on an add, fire on a check.
	assign le    = (rd_time <= key_q);
	assign stall = pend_valid_q && !out_free;

	assign cmd.ready = (state_q == ST_IDLE);

	evtq_mem #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (cmd.command == CMD_ADD) begin
						if (q_full) begin
							state_d = ST_RESP;
						end else if (q_empty) begin
							state_d = ST_ADD_WR;
						end else begin
							state_d = ST_ADD_CMP;
						end
					end else if (!q_empty) begin
						state_d = ST_CHK_CMP;
					end
				end
			end
			ST_ADD_CMP: begin
				if (le) begin
					state_d = ST_RESP;
				end else if (pos_q == IDX_W'(1)) begin
					state_d = ST_ADD_WR;
				end
			end
			ST_ADD_WR: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHK_CMP: begin
				if (!stall) begin
					if (!le) begin
						state_d = ST_IDLE;
					end else if (count_q == CNT_W'(1)) begin
						state_d = ST_CHK_FLUSH;
					end
				end
			end
			ST_CHK_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = head_q;
		wr_en     = 1'b0;
		wr_addr   = slot_of(head_q, pos_q);
		wr_data   = new_entry;
		emit      = 1'b0;
		emit_kind = KIND_ACCEPTED;
		emit_pin  = '0;
		emit_act  = '0;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (acc && !q_empty) begin
					if (cmd.command == CMD_ADD) begin
						if (!q_full) begin
							rd_en   = 1'b1;
							rd_addr = slot_of(head_q, cnt_m1[IDX_W-1:0]);
						end
					end else begin
						rd_en   = 1'b1;
						rd_addr = head_q;
					end
				end
			end
			ST_ADD_CMP: begin
				wr_en = 1'b1;
				if (!le) begin
					// Move the later entry one slot on and fetch the one before it.
					wr_data = rd_data;
					if (pos_q != IDX_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = slot_of(head_q, pos_q - IDX_W'(2));
					end
				end
			end
			ST_ADD_WR: begin
				wr_en = 1'b1;
			end
			ST_RESP: begin
				emit      = out_free;
				emit_kind = resp_kind_q;
			end
			ST_CHK_CMP: begin
				if (!stall) begin
					// A fired event is held back until it is known whether another follows.
					emit      = pend_valid_q;
					emit_kind = KIND_FIRED;
					emit_pin  = pend_pin_q;
					emit_act  = pend_act_q;
					emit_last = !le;
					if (le && count_q != CNT_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = slot_of(head_q, IDX_W'(1));
					end
				end
			end
			ST_CHK_FLUSH: begin
				emit      = out_free;
				emit_kind = KIND_FIRED;
				emit_pin  = pend_pin_q;
				emit_act  = pend_act_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					pend_valid_q <= 1'b0;
					if (acc && cmd.command == CMD_ADD && q_empty) begin
						head_q <= '0;
					end
				end
				ST_ADD_CMP: begin
					if (le) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_ADD_WR: begin
					count_q <= count_q + CNT_W'(1);
				end
				ST_CHK_CMP: begin
					if (!stall) begin
						pend_valid_q <= le;
						if (le) begin
							count_q <= cnt_m1;
							head_q  <= (count_q == CNT_W'(1)) ? '0 : slot_of(head_q, IDX_W'(1));
						end
					end
				end
				ST_CHK_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
					pend_valid_q <= pend_valid_q;
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			key_q       <= (cmd.command == CMD_ADD) ? evt_t : now_t;
			pin_q       <= cmd.pin_number;
			act_q       <= cmd.pin_action;
			pos_q       <= count_q[IDX_W-1:0];
			resp_kind_q <= q_full ? KIND_REJECTED : KIND_ACCEPTED;
		end else if (state_q == ST_ADD_CMP && !le) begin
			pos_q <= pos_q - IDX_W'(1);
		end
		if (state_q == ST_CHK_CMP && !stall && le) begin
			pend_pin_q <= rd_pin;
			pend_act_q <= rd_act;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_pin_q  <= emit_pin;
			out_act_q  <= emit_act;
			out_last_q <= emit_last;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_kind  = out_kind_q;
	assign res.fired_pin    = out_pin_q;
	assign res.fired_action = out_act_q;
	assign res.last_result  = out_last_q;
endmodule

// ----- rtl/core/evtq_checker.sv -----
// Port-level checks for the timed event sorted queue, bound to the top level.
module evtq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_command,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [evtq_pkg::KIND_W-1:0]  out_kind,
	input logic [evtq_pkg::PIN_W-1:0]   out_pin,
	input logic [evtq_pkg::ACT_W-1:0]   out_act,
	input logic                         out_last
);
	import evtq_pkg::*;

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_pin)
			&& $stable(out_act) && $stable(out_last))
		else $error("result changed while stalled");

	// Add answers carry no pin or action.
	a_add_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_FIRED |-> out_pin == '0 && out_act == '0)
		else $error("add answer with non-zero pin or action");

	// An add causes exactly one result, so it is always the last.
	a_add_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_FIRED |-> out_last)
		else $error("add answer not marked last");

	// An add always keeps the controller busy, so ready drops after the transfer.
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_command == CMD_ADD |=> !in_ready)
		else $error("ready straight after an add transfer");
endmodule

bind timed_event_sorted_queue evtq_checker u_evtq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd.valid),
	.in_ready   (cmd.ready),
	.in_command (cmd.command),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.out_kind   (res.result_kind),
	.out_pin    (res.fired_pin),
	.out_act    (res.fired_action),
	.out_last   (res.last_result)
);
